/* design/mcc_pkg.sv */
package mcc_pkg;

    // Table entries hold a coin count; the all-ones code marks an amount out of reach.
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] CNT_UNREACH = 11'd2047;
    localparam logic [CNT_W-1:0] CNT_CAP     = 11'd2046;

    localparam int OUT_W = 10;
    localparam logic [CNT_W-1:0] OUT_CAP = 11'd1023;

    localparam int IN_VAL_W = 10;
    localparam int PREFIX_W = 4;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNREACH = 2'd1,
        ST_PREFIX  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;
        logic q_eval;
        logic fill_issue;
        logic fill_done;
        logic push;
    } mcc_cmd_t;

    typedef struct packed {
        logic go_fill;
        logic go_read;
        logic fill_last;
        logic out_free;
    } mcc_stat_t;

endpackage

/* design/min_coin_change_prefix_table.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | op, coin_value, prefix_count, target_value
// out      | out_valid / out_stall| min_coins, status
//
// Load coin: one table entry per cycle through a two-read, one-write memory
// (read row below and same row at v - coin, write v in the next cycle).
// Query: one registered memory read. Clear and rejected ops go straight to the push state.
// Reset clears the loaded-coin count; row zero is generated, so no clearing pass runs.
// One item is worked at a time; a finished result waits in the output register
// while the next item is accepted.
module min_coin_change_prefix_table
    import mcc_pkg::*;
#(
    parameter int N_COINS   = 8,
    parameter int MAX_VALUE = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [IN_VAL_W-1:0] coin_value,
    input  logic [PREFIX_W-1:0] prefix_count,
    input  logic [IN_VAL_W-1:0] target_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_W-1:0]    min_coins,
    output logic [1:0]          status
);

    mcc_cmd_t  cmd;
    mcc_stat_t stat;

    mcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcc_dp #(
        .N_COINS   (N_COINS),
        .MAX_VALUE (MAX_VALUE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .coin_value   (coin_value),
        .prefix_count (prefix_count),
        .target_value (target_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .min_coins    (min_coins),
        .status       (status)
    );

endmodule

/* design/mcc_ctrl.sv */
module mcc_ctrl
    import mcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  mcc_stat_t stat,
    output mcc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FILL,
        S_FLUSH,
        S_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        cmd.q_eval     = (state_reg == S_READ);
        cmd.fill_issue = (state_reg == S_FILL);
        cmd.fill_done  = (state_reg == S_FLUSH);
        cmd.push       = (state_reg == S_PUSH) && stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (stat.go_fill)
                        state_next = S_FILL;
                    else if (stat.go_read)
                        state_next = S_READ;
                    else
                        state_next = S_PUSH;
                end
            end
            S_READ:
                state_next = S_PUSH;
            S_FILL:
            begin
                if (stat.fill_last)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
                state_next = S_PUSH;
            S_PUSH:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/mcc_dp.sv */
module mcc_dp
    import mcc_pkg::*;
#(
    parameter int N_COINS   = 8,
    parameter int MAX_VALUE = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mcc_cmd_t            cmd,
    output mcc_stat_t           stat,
    input  logic [1:0]          op,
    input  logic [IN_VAL_W-1:0] coin_value,
    input  logic [PREFIX_W-1:0] prefix_count,
    input  logic [IN_VAL_W-1:0] target_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_W-1:0]    min_coins,
    output logic [1:0]          status
);

    localparam int ROW_LEN = MAX_VALUE + 1;
    localparam int VAL_W   = $clog2(ROW_LEN);
    localparam int DEPTH   = N_COINS * ROW_LEN;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LD_W    = $clog2(N_COINS + 1);
    localparam int PW      = (LD_W > PREFIX_W) ? LD_W : PREFIX_W;
    localparam int WIDE_W  = (VAL_W > IN_VAL_W) ? VAL_W : IN_VAL_W;

    // Rows 1..N_COINS; row 0 is fixed and generated on the fly.
    cnt_t mem [DEPTH];

    logic [LD_W-1:0]     loaded_reg;
    logic [VAL_W-1:0]    v_reg;
    logic [ADDR_W-1:0]   wr_base_reg;
    logic [ADDR_W-1:0]   below_base_reg;
    logic                first_row_reg;
    logic                coin_one_reg;
    logic                coin_nz_reg;
    logic [IN_VAL_W-1:0] coin_reg;
    logic                s1_valid_reg;
    logic [VAL_W-1:0]    s1_v_reg;
    logic                s1_use_b_reg;
    cnt_t                rd_a_reg;
    cnt_t                rd_b_reg;
    cnt_t                last_best_reg;
    logic                q_zero_row_reg;
    logic                q_zero_tgt_reg;
    status_t             pend_status_reg;
    logic [OUT_W-1:0]    pend_count_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [OUT_W-1:0]    out_count_reg;

    logic              is_load;
    logic              is_query;
    logic              is_clear;
    logic              full;
    logic              prefix_over;
    logic              target_over;
    logic              prefix_nz;
    status_t           imm_status;
    logic [LD_W-1:0]   q_idx;
    logic [ADDR_W-1:0] q_addr;
    logic [ADDR_W-1:0] ld_base;
    logic [WIDE_W-1:0] v_wide;
    logic [WIDE_W-1:0] coin_wide;
    logic              use_b;
    logic [VAL_W-1:0]  b_off;
    logic              rd_a_en;
    logic              rd_b_en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] wr_addr;
    cnt_t              below;
    cnt_t              from;
    cnt_t              cand;
    cnt_t              best;
    cnt_t              q_entry;
    status_t           q_status;
    logic [OUT_W-1:0]  q_count;

    assign is_load     = (op == OP_LOAD);
    assign is_query    = (op == OP_QUERY);
    assign is_clear    = (op == OP_CLEAR);
    assign full        = (loaded_reg == LD_W'(N_COINS));
    assign prefix_over = (PW'(prefix_count) > PW'(loaded_reg));
    assign target_over = (WIDE_W'(target_value) > WIDE_W'(MAX_VALUE));
    assign prefix_nz   = (prefix_count != '0);

    always_comb
    begin
        priority if (is_load && full)
            imm_status = ST_FULL;
        else if (is_query && prefix_over)
            imm_status = ST_PREFIX;
        else if (is_query && target_over)
            imm_status = ST_UNREACH;
        else
            imm_status = ST_OK;
    end

    // Memory row of prefix p sits at index p-1.
    assign q_idx   = LD_W'(LD_W'(PW'(prefix_count)) - LD_W'(1));
    assign q_addr  = ADDR_W'(ADDR_W'(q_idx) * ADDR_W'(ROW_LEN)) + ADDR_W'(target_value);
    assign ld_base = ADDR_W'(ADDR_W'(loaded_reg) * ADDR_W'(ROW_LEN));

    assign v_wide    = WIDE_W'(v_reg);
    assign coin_wide = WIDE_W'(coin_reg);
    assign use_b     = coin_nz_reg && (v_wide >= coin_wide);
    assign b_off     = VAL_W'(v_wide - coin_wide);

    assign rd_a_en = (cmd.accept && is_query && !prefix_over && !target_over && prefix_nz)
                   || (cmd.fill_issue && !first_row_reg);
    // With a coin of one, the needed entry is still being written; take it from last_best_reg.
    assign rd_b_en = cmd.fill_issue && use_b && !coin_one_reg;
    assign addr_a  = cmd.fill_issue ? (below_base_reg + ADDR_W'(v_reg)) : q_addr;
    assign addr_b  = wr_base_reg + ADDR_W'(b_off);
    assign wr_addr = wr_base_reg + ADDR_W'(s1_v_reg);

    always_comb
    begin
        if (first_row_reg)
            below = (s1_v_reg == '0) ? '0 : CNT_UNREACH;
        else
            below = rd_a_reg;
        from = coin_one_reg ? last_best_reg : rd_b_reg;
        cand = (from >= CNT_CAP) ? CNT_CAP : cnt_t'(from + cnt_t'(1));
        if (s1_use_b_reg && (from != CNT_UNREACH) && (cand < below))
            best = cand;
        else
            best = below;
    end

    always_comb
    begin
        if (q_zero_row_reg)
            q_entry = q_zero_tgt_reg ? '0 : CNT_UNREACH;
        else
            q_entry = rd_a_reg;
        if (q_entry == CNT_UNREACH)
        begin
            q_status = ST_UNREACH;
            q_count  = '0;
        end
        else
        begin
            q_status = ST_OK;
            q_count  = (q_entry > OUT_CAP) ? OUT_CAP[OUT_W-1:0] : q_entry[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_en)
            rd_a_reg <= mem[addr_a];
        if (rd_b_en)
            rd_b_reg <= mem[addr_b];
        if (s1_valid_reg)
            mem[wr_addr] <= best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            v_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.fill_issue;
            if (cmd.accept && is_load && !full)
                v_reg <= '0;
            else if (cmd.fill_issue)
                v_reg <= VAL_W'(v_reg + VAL_W'(1));
            if (cmd.accept && is_clear)
                loaded_reg <= '0;
            else if (cmd.fill_done)
                loaded_reg <= LD_W'(loaded_reg + LD_W'(1));
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_status_reg <= imm_status;
            pend_count_reg  <= '0;
            q_zero_row_reg  <= !prefix_nz;
            q_zero_tgt_reg  <= (target_value == '0);
            if (is_load)
            begin
                coin_reg       <= coin_value;
                coin_nz_reg    <= (coin_value != '0);
                coin_one_reg   <= (coin_value == IN_VAL_W'(1));
                first_row_reg  <= (loaded_reg == '0);
                wr_base_reg    <= ld_base;
                below_base_reg <= ld_base - ADDR_W'(ROW_LEN);
            end
        end
        if (cmd.q_eval)
        begin
            pend_status_reg <= q_status;
            pend_count_reg  <= q_count;
        end
        if (cmd.fill_issue)
        begin
            s1_v_reg     <= v_reg;
            s1_use_b_reg <= use_b;
        end
        if (s1_valid_reg)
            last_best_reg <= best;
        if (cmd.push)
        begin
            out_status_reg <= pend_status_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign stat.go_fill   = is_load && !full;
    assign stat.go_read   = is_query && !prefix_over && !target_over;
    assign stat.fill_last = (v_reg == VAL_W'(MAX_VALUE));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign min_coins = out_count_reg;
    assign status    = out_status_reg;

endmodule
